/* hw/rtl/tkh_pkg.sv */
// Shared types, constants and control structs of the top-k min-heap selector.
`default_nettype none
package tkh_pkg;

  // Heap capacity and the widths that follow from it.
  localparam int MAX_KEEP = 16;
  localparam int IDX_W    = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int CNT_W    = $clog2(MAX_KEEP + 1);
  localparam int CH_W     = IDX_W + 2;

  // Fixed field widths of the ports.
  localparam int ID_W    = 32;
  localparam int SCORE_W = 32;
  localparam int LIM_W   = 5;
  localparam int HC_W    = 5;

  // Operation codes of an input word.
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // One heap entry: id above, score below.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] score;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_UP,
    S_UP_CMP,
    S_ROOT_CMP,
    S_DN,
    S_DN_L,
    S_DN_R,
    S_DN_MV,
    S_SC_RD,
    S_SC_CMP,
    S_RES_PUSH,
    S_RES_EMPTY,
    S_RES_ENTRY
  } state_t;

  // Read address source of the heap memory.
  typedef enum logic [2:0] {
    RD_PARENT,
    RD_ROOT,
    RD_LEFT,
    RD_RIGHT,
    RD_SCAN
  } rd_sel_t;

  // Write data source of the heap memory.
  typedef enum logic [1:0] {
    WR_CUR,
    WR_RDATA,
    WR_CAND
  } wr_src_t;

  // Kind of result word loaded into the output register.
  typedef enum logic [1:0] {
    EMIT_PUSH,
    EMIT_EMPTY,
    EMIT_ENTRY
  } emit_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_in;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_src_t wr_src;
    logic    idx_set_count;
    logic    idx_set_zero;
    logic    idx_to_parent;
    logic    idx_to_sel;
    logic    cnt_inc;
    logic    cnt_clr;
    logic    kept_set;
    logic    kept_clr;
    logic    cand_left;
    logic    cand_right;
    logic    drain_init;
    logic    scan_clr;
    logic    scan_inc;
    logic    best_upd;
    logic    take_best;
    logic    emit_en;
    emit_t   emit_kind;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_drain;
    logic lim_zero;
    logic below_lim;
    logic count_zero;
    logic idx_zero;
    logic parent_le;
    logic new_gt_root;
    logic l_in;
    logic r_in;
    logic cand_valid;
    logic scan_end;
    logic scan_taken;
    logic last_entry;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* hw/rtl/top_k_min_heap_selector.sv */
// Push below the limit: the new word starts at the end of the heap and sifts up, one parent
// read and one compare per level it climbs.
// Push at the limit: a word that is kept replaces the root and sifts down; a word that is not
// kept leaves the heap as it is. Drain: each word is picked by a scan over the untaken entries,
// and an empty drain answers with one empty word. One word at a time: the next is taken the
// cycle after the last result of the one before is loaded, while that result still waits.
// Synchronous active-low reset clears the count, sets keep_limit to 16 and empties
// the output register; the heap memory is not cleared and needs no clearing pass.
`default_nettype none
module top_k_min_heap_selector
  import tkh_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [LIM_W-1:0]     cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_operation,
  input  wire logic [ID_W-1:0]      in_item_id,
  input  wire logic [SCORE_W-1:0]   in_item_score,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [ID_W-1:0]      out_entry_id,
  output logic      [SCORE_W-1:0]   out_entry_score,
  output logic                      out_entry_valid,
  output logic                      out_was_kept,
  output logic      [HC_W-1:0]      out_held_count,
  output logic                      out_last
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  tkh_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Heap storage and arithmetic.
  tkh_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_operation   (in_operation),
    .in_item_id     (in_item_id),
    .in_item_score  (in_item_score),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_entry_id   (out_entry_id),
    .out_entry_score(out_entry_score),
    .out_entry_valid(out_entry_valid),
    .out_was_kept   (out_was_kept),
    .out_held_count (out_held_count),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire

/* hw/rtl/tkh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tkh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic                                         re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/tkh_ctrl.sv */
// Controller state machine of the top-k min-heap selector.
`default_nettype none
module tkh_ctrl
  import tkh_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!sts.op_drain) begin
          if (sts.lim_zero) begin
            cmd.kept_clr = 1'b1;
            state_nxt    = S_RES_PUSH;
          end else if (sts.below_lim) begin
            cmd.idx_set_count = 1'b1;
            state_nxt         = S_UP;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_ROOT;
            state_nxt  = S_ROOT_CMP;
          end
        end else if (sts.count_zero) begin
          state_nxt = S_RES_EMPTY;
        end else begin
          cmd.drain_init = 1'b1;
          cmd.scan_clr   = 1'b1;
          state_nxt      = S_SC_RD;
        end
      end
      // Sift up: one parent read and one compare per level.
      S_UP: begin
        if (sts.idx_zero) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_src   = WR_CUR;
          cmd.cnt_inc  = 1'b1;
          cmd.kept_set = 1'b1;
          state_nxt    = S_RES_PUSH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PARENT;
          state_nxt  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd.wr_en = 1'b1;
        if (sts.parent_le) begin
          cmd.wr_src   = WR_CUR;
          cmd.cnt_inc  = 1'b1;
          cmd.kept_set = 1'b1;
          state_nxt    = S_RES_PUSH;
        end else begin
          cmd.wr_src        = WR_RDATA;
          cmd.idx_to_parent = 1'b1;
          state_nxt         = S_UP;
        end
      end
      // Full heap: replace the root only on a strictly greater score.
      S_ROOT_CMP: begin
        if (sts.new_gt_root) begin
          cmd.idx_set_zero = 1'b1;
          cmd.kept_set     = 1'b1;
          state_nxt        = S_DN;
        end else begin
          cmd.kept_clr = 1'b1;
          state_nxt    = S_RES_PUSH;
        end
      end
      // Sift down: read each child, move the smaller up if below the word.
      S_DN: begin
        if (sts.l_in) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LEFT;
          state_nxt  = S_DN_L;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_src = WR_CUR;
          state_nxt  = S_RES_PUSH;
        end
      end
      S_DN_L: begin
        cmd.cand_left = 1'b1;
        if (sts.r_in) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_RIGHT;
          state_nxt  = S_DN_R;
        end else begin
          state_nxt = S_DN_MV;
        end
      end
      S_DN_R: begin
        cmd.cand_right = 1'b1;
        state_nxt      = S_DN_MV;
      end
      S_DN_MV: begin
        cmd.wr_en = 1'b1;
        if (sts.cand_valid) begin
          cmd.wr_src     = WR_CAND;
          cmd.idx_to_sel = 1'b1;
          state_nxt      = S_DN;
        end else begin
          cmd.wr_src = WR_CUR;
          state_nxt  = S_RES_PUSH;
        end
      end
      // Drain: scan untaken entries for the next one in sorted order.
      S_SC_RD: begin
        if (sts.scan_end) begin
          state_nxt = S_RES_ENTRY;
        end else if (sts.scan_taken) begin
          cmd.scan_inc = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_SCAN;
          state_nxt  = S_SC_CMP;
        end
      end
      S_SC_CMP: begin
        cmd.best_upd = 1'b1;
        cmd.scan_inc = 1'b1;
        state_nxt    = S_SC_RD;
      end
      // Result words wait for a free output register.
      S_RES_PUSH: begin
        if (sts.out_free) begin
          cmd.emit_en   = 1'b1;
          cmd.emit_kind = EMIT_PUSH;
          state_nxt     = S_IDLE;
        end
      end
      S_RES_EMPTY: begin
        if (sts.out_free) begin
          cmd.emit_en   = 1'b1;
          cmd.emit_kind = EMIT_EMPTY;
          state_nxt     = S_IDLE;
        end
      end
      S_RES_ENTRY: begin
        if (sts.out_free) begin
          cmd.emit_en   = 1'b1;
          cmd.emit_kind = EMIT_ENTRY;
          cmd.take_best = 1'b1;
          if (sts.last_entry) begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            cmd.scan_clr = 1'b1;
            state_nxt    = S_SC_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/tkh_dp.sv */
// Datapath of the top-k min-heap selector: heap memory, sift and drain registers, output word.
`default_nettype none
module tkh_dp
  import tkh_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  input  wire logic                 cfg_wr_en,
  input  wire logic [LIM_W-1:0]     cfg_wr_data,
  input  wire logic                 in_operation,
  input  wire logic [ID_W-1:0]      in_item_id,
  input  wire logic [SCORE_W-1:0]   in_item_score,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [ID_W-1:0]      out_entry_id,
  output logic      [SCORE_W-1:0]   out_entry_score,
  output logic                      out_entry_valid,
  output logic                      out_was_kept,
  output logic      [HC_W-1:0]      out_held_count,
  output logic                      out_last
);

  // True when a sorts ahead of b: higher score first, then lower id.
  function automatic logic sorts_first(entry_t a, entry_t b);
    if (a.score != b.score) begin
      return a.score > b.score;
    end
    return a.id < b.id;
  endfunction

  logic [LIM_W-1:0]    keep_limit_r;
  logic [CNT_W-1:0]    count_r;
  logic                op_r;
  entry_t              cur_r;
  logic [IDX_W-1:0]    idx_r;
  logic                kept_r;
  entry_t              cand_r;
  logic                cand_valid_r;
  logic [IDX_W-1:0]    cand_idx_r;
  logic [CNT_W-1:0]    scan_r;
  logic [CNT_W-1:0]    emitted_r;
  logic [MAX_KEEP-1:0] taken_r;
  entry_t              best_r;
  logic                have_best_r;
  logic [IDX_W-1:0]    best_idx_r;
  logic                out_valid_r;
  entry_t              out_entry_r;
  logic                out_entry_valid_r;
  logic                out_kept_r;
  logic [HC_W-1:0]     out_held_r;
  logic                out_last_r;

  logic [CNT_W-1:0]    lim;
  logic [CH_W-1:0]     left_ch;
  logic [CH_W-1:0]     right_ch;
  logic [IDX_W-1:0]    parent_idx;
  logic [IDX_W-1:0]    raddr;
  entry_t              rdata;
  entry_t              wdata;
  logic [SCORE_W-1:0]  right_ref;

  // Effective limit saturates at the heap capacity.
  always_comb begin
    if (32'(keep_limit_r) > 32'(MAX_KEEP)) begin
      lim = CNT_W'(MAX_KEEP);
    end else begin
      lim = CNT_W'(keep_limit_r);
    end
  end

  // Heap index arithmetic.
  assign left_ch    = {1'b0, idx_r, 1'b1};
  assign right_ch   = left_ch + CH_W'(1);
  assign parent_idx = (idx_r - IDX_W'(1)) >> 1;

  always_comb begin
    case (cmd.rd_sel)
      RD_PARENT: raddr = parent_idx;
      RD_ROOT:   raddr = '0;
      RD_LEFT:   raddr = left_ch[IDX_W-1:0];
      RD_RIGHT:  raddr = right_ch[IDX_W-1:0];
      RD_SCAN:   raddr = scan_r[IDX_W-1:0];
      default:   raddr = '0;
    endcase
  end

  always_comb begin
    case (cmd.wr_src)
      WR_CUR:   wdata = cur_r;
      WR_RDATA: wdata = rdata;
      WR_CAND:  wdata = cand_r;
      default:  wdata = cur_r;
    endcase
  end

  // Heap storage.
  tkh_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_KEEP)
  ) u_heap (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(idx_r),
    .wdata(wdata),
    .re   (cmd.rd_en),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Reference score for the right child: the current pick so far.
  assign right_ref = cand_valid_r ? cand_r.score : cur_r.score;

  // Status toward the controller.
  always_comb begin
    sts.op_drain    = (op_r == OP_DRAIN);
    sts.lim_zero    = (lim == '0);
    sts.below_lim   = (count_r < lim);
    sts.count_zero  = (count_r == '0);
    sts.idx_zero    = (idx_r == '0);
    sts.parent_le   = (rdata.score <= cur_r.score);
    sts.new_gt_root = (cur_r.score > rdata.score);
    sts.l_in        = (left_ch < CH_W'(count_r));
    sts.r_in        = (right_ch < CH_W'(count_r));
    sts.cand_valid  = cand_valid_r;
    sts.scan_end    = (scan_r == count_r);
    sts.scan_taken  = taken_r[scan_r[IDX_W-1:0]];
    sts.last_entry  = ((emitted_r + CNT_W'(1)) == count_r);
    sts.out_free    = !out_valid_r || out_ready;
  end

  // Control registers: limit, count, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_limit_r <= LIM_W'(16);
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        keep_limit_r <= cfg_wr_data;
      end
      if (cmd.cnt_clr) begin
        count_r <= '0;
      end else if (cmd.cnt_inc) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.emit_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Input word and sift registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_operation;
      cur_r <= '{id: in_item_id, score: in_item_score};
    end
    if (cmd.idx_set_count) begin
      idx_r <= count_r[IDX_W-1:0];
    end else if (cmd.idx_set_zero) begin
      idx_r <= '0;
    end else if (cmd.idx_to_parent) begin
      idx_r <= parent_idx;
    end else if (cmd.idx_to_sel) begin
      idx_r <= cand_idx_r;
    end
    if (cmd.kept_set) begin
      kept_r <= 1'b1;
    end else if (cmd.kept_clr) begin
      kept_r <= 1'b0;
    end
    // Smaller child, strict less-than, left first.
    if (cmd.cand_left) begin
      cand_valid_r <= (rdata.score < cur_r.score);
      cand_r       <= rdata;
      cand_idx_r   <= left_ch[IDX_W-1:0];
    end else if (cmd.cand_right && (rdata.score < right_ref)) begin
      cand_valid_r <= 1'b1;
      cand_r       <= rdata;
      cand_idx_r   <= right_ch[IDX_W-1:0];
    end
  end

  // Drain selection registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r     <= '0;
      emitted_r   <= '0;
      scan_r      <= '0;
      have_best_r <= 1'b0;
    end else begin
      if (cmd.drain_init) begin
        taken_r   <= '0;
        emitted_r <= '0;
      end else if (cmd.take_best) begin
        taken_r[best_idx_r] <= 1'b1;
        emitted_r           <= emitted_r + CNT_W'(1);
      end
      if (cmd.scan_clr) begin
        scan_r      <= '0;
        have_best_r <= 1'b0;
      end else begin
        if (cmd.scan_inc) begin
          scan_r <= scan_r + CNT_W'(1);
        end
        if (cmd.best_upd && (!have_best_r || sorts_first(rdata, best_r))) begin
          have_best_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.best_upd && (!have_best_r || sorts_first(rdata, best_r))) begin
      best_r     <= rdata;
      best_idx_r <= scan_r[IDX_W-1:0];
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (cmd.emit_en) begin
      case (cmd.emit_kind)
        EMIT_PUSH: begin
          out_entry_r       <= '0;
          out_entry_valid_r <= 1'b0;
          out_kept_r        <= kept_r;
          out_held_r        <= HC_W'(count_r);
          out_last_r        <= 1'b1;
        end
        EMIT_ENTRY: begin
          out_entry_r       <= best_r;
          out_entry_valid_r <= 1'b1;
          out_kept_r        <= 1'b0;
          out_held_r        <= '0;
          out_last_r        <= sts.last_entry;
        end
        default: begin
          out_entry_r       <= '0;
          out_entry_valid_r <= 1'b0;
          out_kept_r        <= 1'b0;
          out_held_r        <= '0;
          out_last_r        <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_entry_id    = out_entry_r.id;
  assign out_entry_score = out_entry_r.score;
  assign out_entry_valid = out_entry_valid_r;
  assign out_was_kept    = out_kept_r;
  assign out_held_count  = out_held_r;
  assign out_last        = out_last_r;

endmodule
`default_nettype wire
